>>> rtl/rsmp_pkg.sv
`timescale 1ns / 1ps
package rsmp_pkg;

    localparam int unsigned SLOTS_DEF = 16;
    localparam logic [30:0] DRAW_MAX  = 31'h7FFF_FFFF;

    localparam logic OP_OFFER = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    localparam logic [1:0] CFG_KEEP_COUNT = 2'd0;
    localparam logic [1:0] CFG_KEEP_ORDER = 2'd1;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_DIVN  = 4'd1;
    localparam logic [3:0] ST_MUL   = 4'd2;
    localparam logic [3:0] ST_TEST  = 4'd3;
    localparam logic [3:0] ST_DIVK  = 4'd4;
    localparam logic [3:0] ST_DIVS  = 4'd5;
    localparam logic [3:0] ST_SHRD  = 4'd6;
    localparam logic [3:0] ST_SHWR  = 4'd7;
    localparam logic [3:0] ST_FLRD  = 4'd8;
    localparam logic [3:0] ST_FLOUT = 4'd9;
    localparam logic [3:0] ST_SHEND = 4'd10;

    typedef logic [3:0] state_t;

endpackage

>>> rtl/reservoir_sampler.sv
`timescale 1ns / 1ps
// Reservoir sampler: keeps up to keep_count handles out of a stream.
// Command channel: an item is taken when start is high and busy is low.
// opcode OFFER runs the accept test; opcode FLUSH reads the kept handles
// out and restarts the stream.
// Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; write
// only while busy is low.
// Offer: a bit-serial divide (DRAW_MAX / item number), then scale and
// test. Replacing into a full reservoir of more than one slot adds two
// more divides on the same divider for the slot choice; in order-keeping
// mode the slot memory shift takes a read and a write per moved slot,
// plus one final write. Flush: one result per kept handle (one result
// when nothing is kept), each shown for a single cycle with strobe high;
// the receiver cannot stall, so results are never held back.
// A keep_count of 0 keeps one handle; one above SLOTS keeps SLOTS.
// Reset sets keep_count and the item number to 1 and clears keep_order
// and the kept count; slot contents stay undefined.
module reservoir_sampler
    import rsmp_pkg::*;
#(
    parameter int unsigned SLOTS = SLOTS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        opcode,
    input  logic [31:0] item_handle,
    input  logic [30:0] accept_draw,
    input  logic [30:0] slot_draw,
    output logic        strobe,
    output logic [31:0] kept_handle,
    output logic        is_empty,
    output logic        short_stream,
    output logic        last_of_run,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [4:0]  cfg_data
);

    localparam int unsigned KW = $clog2(SLOTS + 1);
    localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    state_t          state_reg, state_next;
    logic [4:0]      keep_count_reg;
    logic            keep_order_reg;
    logic [KW-1:0]   kept_total_reg, kept_total_next;
    logic [31:0]     item_number_reg, item_number_next;
    logic [31:0]     handle_reg, handle_next;
    logic [30:0]     adraw_reg, adraw_next;
    logic [30:0]     sdraw_reg, sdraw_next;
    logic [31:0]     dq_reg, dq_next;
    logic [KW+31:0]  prod_reg, prod_next;
    logic [30:0]     dvd_reg, dvd_next;
    logic [31:0]     vsr_reg, vsr_next;
    logic [31:0]     rem_reg, rem_next;
    logic [4:0]      cnt_reg, cnt_next;
    logic [AW-1:0]   j_reg, j_next;
    logic            strobe_reg, strobe_next;
    logic [31:0]     kept_handle_reg, kept_handle_next;
    logic            is_empty_reg, is_empty_next;
    logic            short_reg, short_next;
    logic            last_reg, last_next;

    logic [31:0]     mem [SLOTS];
    logic [31:0]     rdata_reg;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [31:0]     mem_wdata;
    logic [AW-1:0]   mem_raddr;

    logic [KW-1:0]   k_eff;
    logic [32:0]     rem_sh;
    logic            div_ge;
    logic [31:0]     rem_step;
    logic [30:0]     quot;
    logic            div_done;
    logic [AW-1:0]   slot_idx;
    logic            shrt;

    always_comb
    begin
        if (keep_count_reg == 5'd0)
            k_eff = KW'(1);
        else if (32'(keep_count_reg) > 32'(SLOTS))
            k_eff = KW'(SLOTS);
        else
            k_eff = KW'(keep_count_reg);
    end

    assign rem_sh   = {rem_reg, dvd_reg[30]};
    assign div_ge   = rem_sh >= {1'b0, vsr_reg};
    assign rem_step = div_ge ? 32'(rem_sh - {1'b0, vsr_reg}) : rem_sh[31:0];
    assign quot     = {dvd_reg[29:0], div_ge};
    assign div_done = cnt_reg == 5'd30;
    assign slot_idx = (quot >= 31'(k_eff)) ? AW'(k_eff - KW'(1)) : AW'(quot);
    assign shrt     = kept_total_reg < k_eff;

    assign busy         = state_reg != ST_IDLE;
    assign cfg_ready    = 1'b1;
    assign strobe       = strobe_reg;
    assign kept_handle  = kept_handle_reg;
    assign is_empty     = is_empty_reg;
    assign short_stream = short_reg;
    assign last_of_run  = last_reg;

    always_comb
    begin
        state_next       = state_reg;
        kept_total_next  = kept_total_reg;
        item_number_next = item_number_reg;
        handle_next      = handle_reg;
        adraw_next       = adraw_reg;
        sdraw_next       = sdraw_reg;
        dq_next          = dq_reg;
        prod_next        = prod_reg;
        dvd_next         = dvd_reg;
        vsr_next         = vsr_reg;
        rem_next         = rem_reg;
        cnt_next         = cnt_reg;
        j_next           = j_reg;
        strobe_next      = 1'b0;
        kept_handle_next = kept_handle_reg;
        is_empty_next    = is_empty_reg;
        short_next       = short_reg;
        last_next        = last_reg;
        mem_we           = 1'b0;
        mem_waddr        = j_reg;
        mem_wdata        = handle_reg;
        mem_raddr        = j_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    handle_next = item_handle;
                    adraw_next  = accept_draw;
                    sdraw_next  = slot_draw;
                    if (opcode == OP_OFFER)
                    begin
                        dvd_next   = DRAW_MAX;
                        vsr_next   = item_number_reg;
                        rem_next   = 32'd0;
                        cnt_next   = 5'd0;
                        state_next = ST_DIVN;
                    end
                    else if (kept_total_reg == KW'(0))
                    begin
                        strobe_next      = 1'b1;
                        kept_handle_next = 32'd0;
                        is_empty_next    = 1'b1;
                        short_next       = 1'b1;
                        last_next        = 1'b1;
                        item_number_next = 32'd1;
                    end
                    else
                    begin
                        j_next     = '0;
                        state_next = ST_FLRD;
                    end
                end
            end
            ST_DIVN, ST_DIVK, ST_DIVS:
            begin
                dvd_next = quot;
                rem_next = rem_step;
                cnt_next = cnt_reg + 5'd1;
                if (div_done)
                begin
                    if (state_reg == ST_DIVN)
                    begin
                        dq_next    = 32'(quot) + 32'd1;
                        state_next = ST_MUL;
                    end
                    else if (state_reg == ST_DIVK)
                    begin
                        dvd_next   = sdraw_reg;
                        vsr_next   = 32'(quot) + 32'd1;
                        rem_next   = 32'd0;
                        cnt_next   = 5'd0;
                        state_next = ST_DIVS;
                    end
                    else if (keep_order_reg == 1'b0)
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = slot_idx;
                        state_next = ST_IDLE;
                    end
                    else if ((KW'(slot_idx) + KW'(1)) < kept_total_reg)
                    begin
                        j_next     = slot_idx;
                        state_next = ST_SHRD;
                    end
                    else
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = AW'(kept_total_reg - KW'(1));
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_MUL:
            begin
                prod_next  = (KW + 32)'(k_eff) * (KW + 32)'(dq_reg);
                state_next = ST_TEST;
            end
            ST_TEST:
            begin
                if (item_number_reg != 32'hFFFF_FFFF)
                    item_number_next = item_number_reg + 32'd1;
                state_next = ST_IDLE;
                if ((KW + 32)'(adraw_reg) < prod_reg)
                begin
                    if (kept_total_reg < k_eff)
                    begin
                        mem_we          = 1'b1;
                        mem_waddr       = AW'(kept_total_reg);
                        kept_total_next = kept_total_reg + KW'(1);
                    end
                    else if (k_eff == KW'(1))
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = '0;
                    end
                    else
                    begin
                        dvd_next   = DRAW_MAX;
                        vsr_next   = 32'(k_eff);
                        rem_next   = 32'd0;
                        cnt_next   = 5'd0;
                        state_next = ST_DIVK;
                    end
                end
            end
            ST_SHRD:
            begin
                mem_raddr  = AW'(KW'(j_reg) + KW'(1));
                state_next = ST_SHWR;
            end
            ST_SHWR:
            begin
                mem_we    = 1'b1;
                mem_waddr = j_reg;
                mem_wdata = rdata_reg;
                j_next    = AW'(KW'(j_reg) + KW'(1));
                if ((KW'(j_reg) + KW'(2)) < kept_total_reg)
                    state_next = ST_SHRD;
                else
                    state_next = ST_SHEND;
            end
            ST_SHEND:
            begin
                mem_we     = 1'b1;
                mem_waddr  = AW'(kept_total_reg - KW'(1));
                state_next = ST_IDLE;
            end
            ST_FLRD:
            begin
                mem_raddr  = j_reg;
                state_next = ST_FLOUT;
            end
            ST_FLOUT:
            begin
                strobe_next      = 1'b1;
                kept_handle_next = rdata_reg;
                is_empty_next    = 1'b0;
                short_next       = shrt;
                last_next        = (KW'(j_reg) + KW'(1)) == kept_total_reg;
                j_next           = AW'(KW'(j_reg) + KW'(1));
                if ((KW'(j_reg) + KW'(1)) == kept_total_reg)
                begin
                    kept_total_next  = '0;
                    item_number_next = 32'd1;
                    state_next       = ST_IDLE;
                end
                else
                    state_next = ST_FLRD;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (state_reg == ST_IDLE && start && opcode == OP_FLUSH
            && kept_total_reg == KW'(0))
            kept_total_next = '0;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rdata_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            keep_count_reg  <= 5'd1;
            keep_order_reg  <= 1'b0;
            kept_total_reg  <= '0;
            item_number_reg <= 32'd1;
            strobe_reg      <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            kept_total_reg  <= kept_total_next;
            item_number_reg <= item_number_next;
            strobe_reg      <= strobe_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_KEEP_COUNT)
                    keep_count_reg <= cfg_data;
                else if (cfg_index == CFG_KEEP_ORDER)
                    keep_order_reg <= cfg_data[0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        handle_reg      <= handle_next;
        adraw_reg       <= adraw_next;
        sdraw_reg       <= sdraw_next;
        dq_reg          <= dq_next;
        prod_reg        <= prod_next;
        dvd_reg         <= dvd_next;
        vsr_reg         <= vsr_next;
        rem_reg         <= rem_next;
        cnt_reg         <= cnt_next;
        j_reg           <= j_next;
        kept_handle_reg <= kept_handle_next;
        is_empty_reg    <= is_empty_next;
        short_reg       <= short_next;
        last_reg        <= last_next;
    end

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import rsmp_pkg::*;

    class reservoir_scoreboard;
        logic [31:0] slot_mem [16];
        int unsigned kept_total;
        logic [31:0] item_number;
        logic [4:0]  keep_count;
        logic        keep_order;
        logic [34:0] pending_results [$];
        int          failures;

        function new();
            kept_total = 0;
            item_number = 1;
            keep_count = 1;
            keep_order = 0;
            failures = 0;
        endfunction

        function void set_register(logic [1:0] idx, logic [4:0] value);
            if (idx == CFG_KEEP_COUNT)
                keep_count = value;
            else if (idx == CFG_KEEP_ORDER)
                keep_order = value[0];
        endfunction

        function void note_item(logic op, logic [31:0] handle, logic [30:0] adraw,
                                logic [30:0] sdraw);
            int unsigned k;
            longint unsigned q;
            int unsigned slot_idx;
            logic shrt;
            k = (keep_count < 1) ? 1 : (keep_count > 16 ? 16 : keep_count);
            if (op == OP_OFFER) begin
                q = longint'(adraw) / (64'(DRAW_MAX) / longint'(item_number) + 1);
                if (q < k) begin
                    if (kept_total < k) begin
                        slot_mem[kept_total] = handle;
                        kept_total++;
                    end
                    else begin
                        slot_idx = 0;
                        if (k > 1) begin
                            q = longint'(sdraw) / (64'(DRAW_MAX) / k + 1);
                            slot_idx = (q >= k) ? k - 1 : int'(q);
                        end
                        if (k == 1 || !keep_order)
                            slot_mem[slot_idx] = handle;
                        else begin
                            for (int j = slot_idx; j + 1 < kept_total; j++)
                                slot_mem[j] = slot_mem[j + 1];
                            slot_mem[kept_total - 1] = handle;
                        end
                    end
                end
                if (item_number != 32'hFFFF_FFFF)
                    item_number++;
            end
            else begin
                shrt = (kept_total < k);
                if (kept_total == 0)
                    pending_results.push_back({32'h0, 1'b1, shrt, 1'b1});
                else
                    for (int j = 0; j < kept_total; j++)
                        pending_results.push_back({slot_mem[j], 1'b0, shrt,
                                                   1'(j + 1 == kept_total)});
                kept_total = 0;
                item_number = 1;
            end
        endfunction

        function void check_result(logic [31:0] handle, logic empty, logic shrt,
                                   logic last);
            logic [34:0] exp_r;
            if (pending_results.size() == 0) begin
                $error("unexpected result handle=%h", handle);
                failures++;
                return;
            end
            exp_r = pending_results.pop_front();
            if (exp_r[34:3] !== handle) begin
                $error("kept_handle expected %h actual %h", exp_r[34:3], handle);
                failures++;
            end
            if (exp_r[2] !== empty) begin
                $error("is_empty expected %b actual %b", exp_r[2], empty);
                failures++;
            end
            if (exp_r[1] !== shrt) begin
                $error("short_stream expected %b actual %b", exp_r[1], shrt);
                failures++;
            end
            if (exp_r[0] !== last) begin
                $error("last_of_run expected %b actual %b", exp_r[0], last);
                failures++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        opcode;
    logic [31:0] item_handle;
    logic [30:0] accept_draw;
    logic [30:0] slot_draw;
    logic        strobe;
    logic [31:0] kept_handle;
    logic        is_empty;
    logic        short_stream;
    logic        last_of_run;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [4:0]  cfg_data;

    reservoir_scoreboard sampler_model;
    bit no_gaps;

    reservoir_sampler DUT (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
        if (rst_n && strobe && sampler_model != null)
            sampler_model.check_result(kept_handle, is_empty, short_stream, last_of_run);

    task automatic write_register(logic [1:0] idx, logic [4:0] value);
        @(negedge clk);
        while (busy)
            @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        sampler_model.set_register(idx, value);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_item(logic op, logic [31:0] handle, logic [30:0] adraw,
                             logic [30:0] sdraw);
        @(negedge clk);
        while (!no_gaps && $urandom_range(99) < 19)
            @(negedge clk);
        start       <= 1'b1;
        opcode      <= op;
        item_handle <= handle;
        accept_draw <= adraw;
        slot_draw   <= sdraw;
        do @(posedge clk); while (busy);
        sampler_model.note_item(op, handle, adraw, sdraw);
        @(negedge clk);
        start <= 1'b0;
    endtask

    task automatic drain_results();
        while (sampler_model.pending_results.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic offer_random(int unsigned n);
        logic [30:0] adraw;
        for (int i = 0; i < n; i++) begin
            adraw = 31'($urandom);
            if ($urandom_range(3) == 0)
                adraw = 31'($urandom_range(4000));
            send_item(OP_OFFER, $urandom, adraw, 31'($urandom));
        end
    endtask

    initial
    begin
        #50_000_000;
        $display("testbench NOT OK");
        $finish;
    end

    initial
    begin
        logic [4:0] counts [8];
        sampler_model = new();
        rst_n = 1'b0;
        start = 1'b0;
        opcode = OP_OFFER;
        item_handle = '0;
        accept_draw = '0;
        slot_draw = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_KEEP_COUNT;
        cfg_data = '0;
        no_gaps = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_item(OP_FLUSH, '0, '0, '0);
        send_item(OP_OFFER, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        send_item(OP_OFFER, 32'h0, 31'h0, 31'h0);
        send_item(OP_FLUSH, $urandom, 31'($urandom), 31'($urandom));
        drain_results();
        write_register(CFG_KEEP_COUNT, 5'd4);
        write_register(CFG_KEEP_ORDER, 5'd1);
        for (int i = 0; i < 8; i++)
            send_item(OP_OFFER, 32'hA000_0000 + i, 31'h0, (i % 2) ? 31'h7FFF_FFFF : 31'h0);
        send_item(OP_OFFER, 32'h5555_AAAA, 31'h0, 31'h4000_0000);
        write_register(CFG_KEEP_COUNT, 5'd2);
        send_item(OP_OFFER, 32'hAAAA_5555, 31'h0, 31'h7FFF_FFFF);
        send_item(OP_FLUSH, '0, '0, '0);
        drain_results();
        write_register(CFG_KEEP_COUNT, 5'd0);
        send_item(OP_OFFER, 32'h1234_5678, 31'h0, 31'h0);
        send_item(OP_OFFER, 32'h8765_4321, 31'h0, 31'h0);
        send_item(OP_FLUSH, '0, '0, '0);
        drain_results();
        write_register(CFG_KEEP_COUNT, 5'd31);
        send_item(OP_OFFER, 32'hDEAD_BEEF, 31'h7FFF_FFFF, 31'h0);
        send_item(OP_FLUSH, '0, '0, '0);
        drain_results();

        counts = '{5'd16, 5'd1, 5'd3, 5'd8, 5'd20, 5'd5, 5'd16, 5'd2};
        for (int phase = 0; phase < 8; phase++) begin
            write_register(CFG_KEEP_COUNT, counts[phase]);
            write_register(CFG_KEEP_ORDER, 5'(phase[0]));
            no_gaps = (phase == 3);
            for (int s = 0; s < 3; s++) begin
                offer_random($urandom_range(22));
                send_item(OP_FLUSH, $urandom, 31'($urandom), 31'($urandom));
            end
            drain_results();
        end

        if (sampler_model.failures == 0 && sampler_model.pending_results.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end
endmodule

>>> files.f
rtl/rsmp_pkg.sv
rtl/reservoir_sampler.sv
test/testbench.sv
